[design/assert_macros.svh]
// assertion macros used by the checker file tcw_checker
// every macro samples on the rising edge of clk and is quiet while arst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define TCW_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tcw check failed");

// consequent must hold in the cycle after the antecedent
`define TCW_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tcw check failed");

`endif

[design/tcw_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package tcw_pkg;

	// default sizes of the cell store and tab step
	localparam int DEF_MAX_COLUMNS = 128;
	localparam int DEF_MAX_ROWS    = 64;
	localparam int DEF_TAB_STEP    = 5;

	// field widths
	localparam int CHAR_W    = 8;
	localparam int COL_W     = 7;
	localparam int LINE_W    = 6;
	localparam int CELL_W    = 16;
	localparam int CFG_IDX_W = 4;
	localparam int CFG_DAT_W = 8;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_COLUMNS    = 4'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_ROWS       = 4'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BACKGROUND_COLOUR = 4'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_FOREGROUND_COLOUR = 4'd3;

	// configuration reset values
	localparam logic [7:0] RST_SCREEN_COLUMNS = 8'd80;
	localparam logic [6:0] RST_SCREEN_ROWS    = 7'd25;
	localparam logic [3:0] RST_BACKGROUND     = 4'd0;
	localparam logic [3:0] RST_FOREGROUND     = 4'd7;

	// control characters
	localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
	localparam logic [CHAR_W-1:0] CH_TAB       = 8'd9;
	localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
	localparam logic [CHAR_W-1:0] CH_RETURN    = 8'd13;

	// controller to datapath commands
	typedef struct packed {
		logic load_char;
		logic exec;
		logic bs_commit;
		logic copy_step;
		logic fill_step;
		logic clear_step;
		logic cnt_reset;
		logic load_out;
	} ctl_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic is_bs;
		logic need_scroll;
		logic copy_last;
		logic fill_last;
		logic clear_last;
	} ctl_sts_t;

endpackage

`default_nettype wire

[design/text_console_character_writer_core.sv]
// ordinary characters go through the decode state to the output register; backspace adds a commit state
// a scroll adds a copy pass, a drain state and a fill pass: one cell copied or blanked per cycle
// a new character is taken only in the idle and output states of the controller
// the cell store has one write and one read port, so scroll and backspace are serialised on it
// reset: asynchronous, active low; afterwards a clearing pass zeroes the store, one cell a cycle
// with input stalled; config is taken as ever
`timescale 1ns / 1ps
`default_nettype none

module text_console_character_writer_core #(
	parameter int MAX_COLUMNS = tcw_pkg::DEF_MAX_COLUMNS,
	parameter int MAX_ROWS    = tcw_pkg::DEF_MAX_ROWS,
	parameter int TAB_STEP    = tcw_pkg::DEF_TAB_STEP
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [tcw_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tcw_pkg::CFG_DAT_W-1:0]  cfg_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [tcw_pkg::CHAR_W-1:0]     char_code,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [tcw_pkg::COL_W-1:0]      cursor_column,
	output logic [tcw_pkg::LINE_W-1:0]     cursor_line,
	output logic                           did_scroll,
	output logic                           cell_written,
	output logic [tcw_pkg::COL_W-1:0]      written_column,
	output logic [tcw_pkg::LINE_W-1:0]     written_line,
	output logic [tcw_pkg::CELL_W-1:0]     written_cell
);
	import tcw_pkg::*;

	ctl_cmd_t cmd;
	ctl_sts_t sts;

	// configuration writes are always taken
	assign cfg_ready = 1'b1;

	tcw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	tcw_datapath #(
		.MAX_COLUMNS (MAX_COLUMNS),
		.MAX_ROWS    (MAX_ROWS),
		.TAB_STEP    (TAB_STEP)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_valid && cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.char_code      (char_code),
		.cmd            (cmd),
		.sts            (sts),
		.cursor_column  (cursor_column),
		.cursor_line    (cursor_line),
		.did_scroll     (did_scroll),
		.cell_written   (cell_written),
		.written_column (written_column),
		.written_line   (written_line),
		.written_cell   (written_cell)
	);

endmodule

`default_nettype wire

[design/tcw_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module tcw_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	output logic                out_valid,
	input  logic                out_stall,
	input  tcw_pkg::ctl_sts_t   sts,
	output tcw_pkg::ctl_cmd_t   cmd
);
	import tcw_pkg::*;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DECODE,
		ST_BS,
		ST_SCROLL,
		ST_DRAIN,
		ST_FILL,
		ST_OUT
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	assign out_valid = out_valid_q;
	// output register can take a new result this cycle
	assign out_free  = !out_valid_q || !out_stall;

	// command decode per state
	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			ST_CLEAR: begin
				cmd.clear_step = 1'b1;
			end
			ST_IDLE: begin
				in_stall      = 1'b0;
				cmd.load_char = in_valid;
			end
			ST_DECODE: begin
				cmd.exec      = 1'b1;
				cmd.cnt_reset = 1'b1;
			end
			ST_BS: begin
				cmd.bs_commit = 1'b1;
			end
			ST_SCROLL: begin
				cmd.copy_step = 1'b1;
			end
			ST_DRAIN: begin
				cmd.cnt_reset = 1'b1;
			end
			ST_FILL: begin
				cmd.fill_step = 1'b1;
			end
			ST_OUT: begin
				in_stall      = !out_free;
				cmd.load_out  = out_free;
				cmd.load_char = out_free && in_valid;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	// state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					if (sts.clear_last) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (in_valid) state_q <= ST_DECODE;
				end
				ST_DECODE: begin
					if (sts.is_bs) begin
						state_q <= ST_BS;
					end else if (sts.need_scroll) begin
						state_q <= ST_SCROLL;
					end else begin
						state_q <= ST_OUT;
					end
				end
				ST_BS: begin
					state_q <= ST_OUT;
				end
				ST_SCROLL: begin
					if (sts.copy_last) state_q <= ST_DRAIN;
				end
				ST_DRAIN: begin
					state_q <= ST_FILL;
				end
				ST_FILL: begin
					if (sts.fill_last) state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_free) begin
						state_q <= in_valid ? ST_DECODE : ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

[design/tcw_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none

module tcw_datapath #(
	parameter int MAX_COLUMNS = tcw_pkg::DEF_MAX_COLUMNS,
	parameter int MAX_ROWS    = tcw_pkg::DEF_MAX_ROWS,
	parameter int TAB_STEP    = tcw_pkg::DEF_TAB_STEP
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [tcw_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [tcw_pkg::CFG_DAT_W-1:0]     cfg_data,
	input  logic [tcw_pkg::CHAR_W-1:0]        char_code,
	input  tcw_pkg::ctl_cmd_t                 cmd,
	output tcw_pkg::ctl_sts_t                 sts,
	output logic [tcw_pkg::COL_W-1:0]         cursor_column,
	output logic [tcw_pkg::LINE_W-1:0]        cursor_line,
	output logic                              did_scroll,
	output logic                              cell_written,
	output logic [tcw_pkg::COL_W-1:0]         written_column,
	output logic [tcw_pkg::LINE_W-1:0]        written_line,
	output logic [tcw_pkg::CELL_W-1:0]        written_cell
);
	import tcw_pkg::*;

	localparam int Depth = MAX_ROWS * MAX_COLUMNS;
	localparam int AW    = $clog2(Depth);
	localparam int CW    = $clog2(MAX_COLUMNS);
	localparam int RW    = $clog2(MAX_ROWS);
	localparam int SW    = CW + 5;

	localparam logic [8:0]    MaxColsL   = 9'(MAX_COLUMNS);
	localparam logic [7:0]    MaxRowsL   = 8'(MAX_ROWS);
	localparam logic [CW-1:0] MaxColLast = CW'(MAX_COLUMNS - 1);
	localparam logic [RW-1:0] MaxRowLast = RW'(MAX_ROWS - 1);

	// flat cell address of a row and column
	function automatic logic [AW-1:0] addr_of(input logic [RW-1:0] row,
		input logic [CW-1:0] col);
		addr_of = AW'(AW'(row) * AW'(MAX_COLUMNS)) + AW'(col);
	endfunction

	// configuration registers
	logic [7:0] scr_cols_q;
	logic [6:0] scr_rows_q;
	logic [3:0] bg_q;
	logic [3:0] fg_q;

	// cursor, character and counters
	logic [CW-1:0]     cur_col_q;
	logic [RW-1:0]     cur_line_q;
	logic [CHAR_W-1:0] ch_q;
	logic [CW-1:0]     cnt_col_q;
	logic [RW-1:0]     cnt_row_q;

	// result of the current character
	logic              res_scroll_q;
	logic              res_written_q;
	logic [CW-1:0]     res_wcol_q;
	logic [RW-1:0]     res_wline_q;
	logic [CELL_W-1:0] res_wcell_q;
	logic [AW-1:0]     bs_addr_q;

	// output register
	logic [COL_W-1:0]  out_col_q;
	logic [LINE_W-1:0] out_line_q;
	logic              out_scroll_q;
	logic              out_written_q;
	logic [COL_W-1:0]  out_wcol_q;
	logic [LINE_W-1:0] out_wline_q;
	logic [CELL_W-1:0] out_wcell_q;

	// cell store and its scroll copy stage
	logic [CELL_W-1:0] cell_mem_q [0:Depth-1];
	logic [CELL_W-1:0] rd_data_s1;
	logic              cp_valid_s1;
	logic [AW-1:0]     cp_addr_s1;

	logic [CW-1:0]     last_col;
	logic [RW-1:0]     last_row;
	logic [7:0]        attr;
	logic [CW-1:0]     col_c;
	logic [RW-1:0]     line_c;
	logic              at_last_col;
	logic              at_last_row;
	logic [RW-1:0]     next_line;
	logic [CW-1:0]     bs_col;
	logic [SW-1:0]     tab_sum;
	logic [CW-1:0]     n_col;
	logic [RW-1:0]     n_line;
	logic              n_scroll;
	logic              n_written;
	logic              n_print;
	logic [AW-1:0]     rd_addr;
	logic              we;
	logic [AW-1:0]     wa;
	logic [CELL_W-1:0] wd;
	logic [CW-1:0]     col_lim;
	logic [RW-1:0]     row_lim;

	// configured size saturated to the store
	always_comb begin
		if (scr_cols_q < 8'd2) begin
			last_col = CW'(1);
		end else if ({1'b0, scr_cols_q} > MaxColsL) begin
			last_col = MaxColLast;
		end else begin
			last_col = CW'(scr_cols_q - 8'd1);
		end
		if (scr_rows_q < 7'd2) begin
			last_row = RW'(1);
		end else if ({1'b0, scr_rows_q} > MaxRowsL) begin
			last_row = MaxRowLast;
		end else begin
			last_row = RW'(scr_rows_q - 7'd1);
		end
	end

	assign attr = {bg_q, fg_q};

	// cursor saturated to the current size
	assign col_c       = (cur_col_q > last_col) ? last_col : cur_col_q;
	assign line_c      = (cur_line_q > last_row) ? last_row : cur_line_q;
	assign at_last_col = (col_c == last_col);
	assign at_last_row = (line_c == last_row);
	assign next_line   = at_last_row ? line_c : line_c + RW'(1);
	assign bs_col      = (col_c == '0) ? '0 : col_c - CW'(1);
	assign tab_sum     = SW'(col_c) + SW'(TAB_STEP);

	// character decode
	always_comb begin
		n_col     = col_c;
		n_line    = line_c;
		n_scroll  = 1'b0;
		n_written = 1'b0;
		n_print   = 1'b0;
		case (ch_q)
			CH_NEWLINE: begin
				n_col    = '0;
				n_line   = next_line;
				n_scroll = at_last_row;
			end
			CH_BACKSPACE: begin
				n_col     = bs_col;
				n_written = 1'b1;
			end
			CH_RETURN: begin
				n_col = '0;
			end
			CH_TAB: begin
				if (tab_sum > SW'(last_col)) begin
					n_col    = '0;
					n_line   = next_line;
					n_scroll = at_last_row;
				end else begin
					n_col = CW'(tab_sum);
				end
			end
			default: begin
				n_written = 1'b1;
				n_print   = 1'b1;
				if (at_last_col) begin
					n_col    = '0;
					n_line   = next_line;
					n_scroll = at_last_row;
				end else begin
					n_col = col_c + CW'(1);
				end
			end
		endcase
	end

	// status to the controller
	assign sts.is_bs       = (ch_q == CH_BACKSPACE);
	assign sts.need_scroll = n_scroll;
	assign sts.copy_last   = (cnt_row_q == last_row - RW'(1)) && (cnt_col_q == last_col);
	assign sts.fill_last   = (cnt_col_q == last_col);
	assign sts.clear_last  = (cnt_row_q == MaxRowLast) && (cnt_col_q == MaxColLast);

	// store read address: row below during scroll, backspace cell otherwise
	assign rd_addr = cmd.copy_step ? addr_of(cnt_row_q + RW'(1), cnt_col_q)
		: addr_of(line_c, bs_col);

	// store write port
	always_comb begin
		we = 1'b1;
		wa = addr_of(cnt_row_q, cnt_col_q);
		wd = '0;
		if (cmd.clear_step) begin
			wa = addr_of(cnt_row_q, cnt_col_q);
			wd = '0;
		end else if (cp_valid_s1) begin
			wa = cp_addr_s1;
			wd = rd_data_s1;
		end else if (cmd.fill_step) begin
			wa = addr_of(last_row, cnt_col_q);
			wd = {attr, 8'h00};
		end else if (cmd.bs_commit) begin
			wa = bs_addr_q;
			wd = {rd_data_s1[15:8], 8'h00};
		end else if (cmd.exec && n_print) begin
			wa = addr_of(line_c, col_c);
			wd = {attr, ch_q};
		end else begin
			we = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			cell_mem_q[wa] <= wd;
		end
		rd_data_s1 <= cell_mem_q[rd_addr];
	end

	// sweep counter limits
	assign col_lim = cmd.clear_step ? MaxColLast : last_col;
	assign row_lim = cmd.clear_step ? MaxRowLast : last_row - RW'(1);

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scr_cols_q  <= RST_SCREEN_COLUMNS;
			scr_rows_q  <= RST_SCREEN_ROWS;
			bg_q        <= RST_BACKGROUND;
			fg_q        <= RST_FOREGROUND;
			cur_col_q   <= '0;
			cur_line_q  <= '0;
			cnt_col_q   <= '0;
			cnt_row_q   <= '0;
			cp_valid_s1 <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_SCREEN_COLUMNS:    scr_cols_q <= cfg_data;
					CFG_SCREEN_ROWS:       scr_rows_q <= cfg_data[6:0];
					CFG_BACKGROUND_COLOUR: bg_q       <= cfg_data[3:0];
					CFG_FOREGROUND_COLOUR: fg_q       <= cfg_data[3:0];
					default: begin
						scr_cols_q <= scr_cols_q;
					end
				endcase
			end
			if (cmd.exec) begin
				cur_col_q  <= n_col;
				cur_line_q <= n_line;
			end
			if (cmd.cnt_reset) begin
				cnt_col_q <= '0;
				cnt_row_q <= '0;
			end else if (cmd.copy_step || cmd.fill_step || cmd.clear_step) begin
				if (cnt_col_q == col_lim) begin
					cnt_col_q <= '0;
					if (cnt_row_q != row_lim) cnt_row_q <= cnt_row_q + RW'(1);
				end else begin
					cnt_col_q <= cnt_col_q + CW'(1);
				end
			end
			cp_valid_s1 <= cmd.copy_step;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load_char) begin
			ch_q <= char_code;
		end
		cp_addr_s1 <= addr_of(cnt_row_q, cnt_col_q);
		if (cmd.exec) begin
			res_scroll_q  <= n_scroll;
			res_written_q <= n_written;
			res_wcol_q    <= n_print ? col_c : (n_written ? n_col : '0);
			res_wline_q   <= n_written ? line_c : '0;
			res_wcell_q   <= n_print ? {attr, ch_q} : '0;
			bs_addr_q     <= addr_of(line_c, bs_col);
		end else if (cmd.bs_commit) begin
			res_wcell_q <= {rd_data_s1[15:8], 8'h00};
		end
		if (cmd.load_out) begin
			out_col_q     <= COL_W'(cur_col_q);
			out_line_q    <= LINE_W'(cur_line_q);
			out_scroll_q  <= res_scroll_q;
			out_written_q <= res_written_q;
			out_wcol_q    <= COL_W'(res_wcol_q);
			out_wline_q   <= LINE_W'(res_wline_q);
			out_wcell_q   <= res_wcell_q;
		end
	end

	// printable writes report the column before the advance
	assign cursor_column  = out_col_q;
	assign cursor_line    = out_line_q;
	assign did_scroll     = out_scroll_q;
	assign cell_written   = out_written_q;
	assign written_column = out_wcol_q;
	assign written_line   = out_wline_q;
	assign written_cell   = out_wcell_q;

endmodule

`default_nettype wire

[design/tcw_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module tcw_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	input  logic                           cfg_ready,
	input  logic [tcw_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tcw_pkg::CFG_DAT_W-1:0]  cfg_data,
	input  logic                           in_valid,
	input  logic                           in_stall,
	input  logic [tcw_pkg::CHAR_W-1:0]     char_code,
	input  logic                           out_valid,
	input  logic                           out_stall,
	input  logic [tcw_pkg::COL_W-1:0]      cursor_column,
	input  logic [tcw_pkg::LINE_W-1:0]     cursor_line,
	input  logic                           did_scroll,
	input  logic                           cell_written,
	input  logic [tcw_pkg::COL_W-1:0]      written_column,
	input  logic [tcw_pkg::LINE_W-1:0]     written_line,
	input  logic [tcw_pkg::CELL_W-1:0]     written_cell
);

	// a stalled result stays offered
	`TCW_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)

	// a stalled result keeps its cursor, scroll flag, write flag and written cell
	`TCW_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(cursor_column) && $stable(cursor_line) && $stable(did_scroll) && $stable(cell_written) && $stable(written_cell))

	// no direct write means the write fields read zero
	`TCW_ASSERT_NOW(a_no_write_zero, out_valid && !cell_written, written_cell == '0 && written_column == '0 && written_line == '0)

	// a scroll always leaves the cursor at the start of a row
	`TCW_ASSERT_NOW(a_scroll_col0, out_valid && did_scroll, cursor_column == '0)

endmodule

bind text_console_character_writer_core tcw_checker u_tcw_checker (.*);

`default_nettype wire

[verif/text_console_character_writer_checker.sv]
`timescale 1ns / 1ps

module text_console_character_writer_checker #(
	parameter int MAX_COLUMNS = tcw_pkg::DEF_MAX_COLUMNS,
	parameter int MAX_ROWS    = tcw_pkg::DEF_MAX_ROWS,
	parameter int TAB_STEP    = tcw_pkg::DEF_TAB_STEP
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	input  logic                           cfg_ready,
	input  logic [tcw_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tcw_pkg::CFG_DAT_W-1:0]  cfg_data,
	input  logic                           in_valid,
	input  logic                           in_stall,
	input  logic [tcw_pkg::CHAR_W-1:0]     char_code,
	input  logic                           out_valid,
	input  logic                           out_stall,
	input  logic [tcw_pkg::COL_W-1:0]      cursor_column,
	input  logic [tcw_pkg::LINE_W-1:0]     cursor_line,
	input  logic                           did_scroll,
	input  logic                           cell_written,
	input  logic [tcw_pkg::COL_W-1:0]      written_column,
	input  logic [tcw_pkg::LINE_W-1:0]     written_line,
	input  logic [tcw_pkg::CELL_W-1:0]     written_cell,
	output int                             open_results,
	output int                             mismatches
);

	import tcw_pkg::*;

	// one predicted console update per character
	typedef struct packed {
		logic [COL_W-1:0]  col;
		logic [LINE_W-1:0] line;
		logic              scrolled;
		logic              written;
		logic [COL_W-1:0]  wcol;
		logic [LINE_W-1:0] wline;
		logic [CELL_W-1:0] wcell;
	} console_update_t;

	// shadow copy of the screen, cursor and registers
	logic [CELL_W-1:0] shadow_cells [MAX_ROWS*MAX_COLUMNS];
	int unsigned       shadow_col;
	int unsigned       shadow_line;
	logic [7:0]        cols_reg;
	logic [6:0]        rows_reg;
	logic [3:0]        bg_reg;
	logic [3:0]        fg_reg;
	console_update_t   update_q [$];

	// step to the next row, scrolling the visible area when past the bottom
	task automatic next_line(input int unsigned ncols, input int unsigned nrows,
			output logic scrolled);
		scrolled = 1'b0;
		shadow_line++;
		if (shadow_line > nrows - 1) begin
			for (int r = 0; r + 1 < nrows; r++)
				for (int c = 0; c < ncols; c++)
					shadow_cells[r*MAX_COLUMNS + c] = shadow_cells[(r+1)*MAX_COLUMNS + c];
			for (int c = 0; c < ncols; c++)
				shadow_cells[(nrows-1)*MAX_COLUMNS + c] = {bg_reg, fg_reg, 8'h00};
			shadow_line = nrows - 1;
			scrolled = 1'b1;
		end
	endtask

	// apply one character to the shadow console and give its update
	task automatic console_char(input logic [CHAR_W-1:0] ch, output console_update_t upd);
		int unsigned ncols;
		int unsigned nrows;
		int unsigned idx;
		logic        scrolled;
		ncols = cols_reg;
		if (ncols < 2) ncols = 2;
		if (ncols > MAX_COLUMNS) ncols = MAX_COLUMNS;
		nrows = rows_reg;
		if (nrows < 2) nrows = 2;
		if (nrows > MAX_ROWS) nrows = MAX_ROWS;
		upd = '0;
		scrolled = 1'b0;
		// a shrunk screen pulls the cursor back inside
		if (shadow_col > ncols - 1) shadow_col = ncols - 1;
		if (shadow_line > nrows - 1) shadow_line = nrows - 1;
		case (ch)
			CH_NEWLINE: begin
				shadow_col = 0;
				next_line(ncols, nrows, scrolled);
			end
			CH_BACKSPACE: begin
				if (shadow_col > 0) shadow_col--;
				idx = shadow_line*MAX_COLUMNS + shadow_col;
				shadow_cells[idx][7:0] = 8'h00;
				upd.written = 1'b1;
				upd.wcol = COL_W'(shadow_col);
				upd.wline = LINE_W'(shadow_line);
				upd.wcell = shadow_cells[idx];
			end
			CH_RETURN: begin
				shadow_col = 0;
			end
			CH_TAB: begin
				shadow_col += TAB_STEP;
				if (shadow_col > ncols - 1) begin
					shadow_col = 0;
					next_line(ncols, nrows, scrolled);
				end
			end
			default: begin
				idx = shadow_line*MAX_COLUMNS + shadow_col;
				shadow_cells[idx] = {bg_reg, fg_reg, ch};
				upd.written = 1'b1;
				upd.wcol = COL_W'(shadow_col);
				upd.wline = LINE_W'(shadow_line);
				upd.wcell = {bg_reg, fg_reg, ch};
				shadow_col++;
				if (shadow_col > ncols - 1) begin
					shadow_col = 0;
					next_line(ncols, nrows, scrolled);
				end
			end
		endcase
		upd.col = COL_W'(shadow_col);
		upd.line = LINE_W'(shadow_line);
		upd.scrolled = scrolled;
	endtask

	task automatic check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want !== got) begin
			$display("%0t: %s expected %0d actual %0d", $time, name, want, got);
			mismatches++;
		end
	endtask

	// watch the three channels at each edge
	always @(posedge clk) begin : watch
		console_update_t upd;
		if (!arst_n) begin
			for (int i = 0; i < MAX_ROWS*MAX_COLUMNS; i++)
				shadow_cells[i] = '0;
			shadow_col = 0;
			shadow_line = 0;
			cols_reg = RST_SCREEN_COLUMNS;
			rows_reg = RST_SCREEN_ROWS;
			bg_reg = RST_BACKGROUND;
			fg_reg = RST_FOREGROUND;
			update_q.delete();
			mismatches = 0;
			open_results <= 0;
		end else begin
			// result transaction against the oldest prediction
			if (out_valid && !out_stall) begin
				if (update_q.size() == 0) begin
					$display("%0t: unexpected result, expected none actual cursor %0d,%0d",
						$time, cursor_column, cursor_line);
					mismatches++;
				end else begin
					upd = update_q.pop_front();
					check_field("cursor_column", upd.col, cursor_column);
					check_field("cursor_line", upd.line, cursor_line);
					check_field("did_scroll", upd.scrolled, did_scroll);
					check_field("cell_written", upd.written, cell_written);
					check_field("written_column", upd.wcol, written_column);
					check_field("written_line", upd.wline, written_line);
					check_field("written_cell", upd.wcell, written_cell);
				end
			end
			// register write transaction
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_SCREEN_COLUMNS:    cols_reg = cfg_data[7:0];
					CFG_SCREEN_ROWS:       rows_reg = cfg_data[6:0];
					CFG_BACKGROUND_COLOUR: bg_reg = cfg_data[3:0];
					CFG_FOREGROUND_COLOUR: fg_reg = cfg_data[3:0];
					default: ;
				endcase
			end
			// character transaction
			if (in_valid && !in_stall) begin
				console_char(char_code, upd);
				update_q.push_back(upd);
			end
			open_results <= update_q.size();
		end
	end

endmodule

[verif/text_console_character_writer_core_tb.sv]
`timescale 1ns / 1ps

module text_console_character_writer_core_tb;

	import tcw_pkg::*;

	localparam int CYCLE_LIMIT = 6000000;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DAT_W-1:0] cfg_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic [CHAR_W-1:0]    char_code = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [COL_W-1:0]     cursor_column;
	logic [LINE_W-1:0]    cursor_line;
	logic                 did_scroll;
	logic                 cell_written;
	logic [COL_W-1:0]     written_column;
	logic [LINE_W-1:0]    written_line;
	logic [CELL_W-1:0]    written_cell;
	int                   open_results;
	int                   mismatches;

	int                   burst_left = 0;
	int                   cycle_count = 0;

	text_console_character_writer_core u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.char_code      (char_code),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.cursor_column  (cursor_column),
		.cursor_line    (cursor_line),
		.did_scroll     (did_scroll),
		.cell_written   (cell_written),
		.written_column (written_column),
		.written_line   (written_line),
		.written_cell   (written_cell)
	);

	text_console_character_writer_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.char_code      (char_code),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.cursor_column  (cursor_column),
		.cursor_line    (cursor_line),
		.did_scroll     (did_scroll),
		.cell_written   (cell_written),
		.written_column (written_column),
		.written_line   (written_line),
		.written_cell   (written_cell),
		.open_results   (open_results),
		.mismatches     (mismatches)
	);

	// clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// result side: rotating stall patterns plus one long hold-off
	always @(posedge clk) begin : result_side
		static int rx_cycle = 0;
		static int hold_left = 0;
		static int results_seen = 0;
		static bit hold_done = 1'b0;
		if (out_valid && !out_stall) results_seen++;
		rx_cycle++;
		if (!hold_done && results_seen == 300) begin
			hold_left = 600;
			hold_done = 1'b1;
		end
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left--;
		end else begin
			case ((rx_cycle / 96) % 4)
				0: out_stall <= 1'b0;
				1: out_stall <= ($urandom_range(0, 3) == 0);
				2: out_stall <= ($urandom_range(0, 3) != 0);
				default: out_stall <= (rx_cycle % 3 == 0);
			endcase
		end
	end

	// one character transaction, with a random gap at the start of each burst
	task automatic send_char(input logic [CHAR_W-1:0] ch);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		char_code <= ch;
		do @(posedge clk); while (in_stall);
	endtask

	// stop offering and wait for every pending result
	task automatic drain;
		in_valid <= 1'b0;
		do @(posedge clk); while (open_results != 0);
	endtask

	// write all four registers back to back
	task automatic set_screen(input logic [7:0] cols, input logic [6:0] rows,
			input logic [3:0] bg, input logic [3:0] fg);
		logic [CFG_IDX_W-1:0] idx [4];
		logic [CFG_DAT_W-1:0] val [4];
		idx = '{CFG_SCREEN_COLUMNS, CFG_SCREEN_ROWS, CFG_BACKGROUND_COLOUR,
			CFG_FOREGROUND_COLOUR};
		val = '{cols, {1'b0, rows}, {4'h0, bg}, {4'h0, fg}};
		for (int i = 0; i < 4; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx[i];
			cfg_data <= val[i];
			do @(posedge clk); while (!cfg_ready);
		end
		cfg_valid <= 1'b0;
	endtask

	// control bytes weighted up, the rest any byte value
	function automatic logic [CHAR_W-1:0] random_char;
		int r;
		r = $urandom_range(0, 99);
		if (r < 10) return CH_NEWLINE;
		if (r < 18) return CH_BACKSPACE;
		if (r < 26) return CH_TAB;
		if (r < 31) return CH_RETURN;
		return CHAR_W'($urandom_range(0, 255));
	endfunction

	// stimulus and verdict
	initial begin : stimulus
		logic [7:0] ext_cols [5];
		logic [6:0] ext_rows [5];
		logic [7:0] cols;
		logic [6:0] rows;
		int         n_items;
		ext_cols = '{8'd0, 8'd1, 8'd255, 8'd129, 8'd128};
		ext_rows = '{7'd0, 7'd1, 7'd127, 7'd65, 7'd64};

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// reset size: byte extremes, backspace down to and at column zero
		send_char(8'h00);
		send_char(8'hFF);
		send_char(CH_BACKSPACE);
		send_char(CH_BACKSPACE);
		send_char(CH_BACKSPACE);
		send_char(8'h41);
		send_char(CH_RETURN);
		send_char(CH_TAB);
		send_char(CH_NEWLINE);
		drain();

		// smallest screen: wrap, scroll, tab past the edge
		set_screen(8'd2, 7'd2, 4'd15, 4'd0);
		send_char(8'h61);
		send_char(8'h62);
		send_char(8'h63);
		send_char(8'h64);
		send_char(CH_TAB);
		send_char(CH_BACKSPACE);
		send_char(CH_NEWLINE);
		drain();

		// largest screen: move the cursor far out
		set_screen(8'd128, 7'd64, 4'd0, 4'd15);
		repeat (3) send_char(CH_NEWLINE);
		repeat (4) send_char(CH_TAB);
		drain();

		// shrink under the cursor
		set_screen(8'd4, 7'd3, 4'd5, 4'd10);
		send_char(8'h7A);
		send_char(CH_BACKSPACE);
		drain();

		// random phases, mostly small screens
		for (int ph = 0; ph < 40; ph++) begin
			if (ph % 8 == 0) begin
				cols = ext_cols[ph / 8];
				rows = ext_rows[ph / 8];
				n_items = 12;
			end else if (ph % 8 == 4) begin
				cols = 8'($urandom_range(2, 80));
				rows = 7'($urandom_range(2, 25));
				n_items = 31;
			end else begin
				cols = 8'($urandom_range(2, 20));
				rows = 7'($urandom_range(2, 10));
				n_items = 31;
			end
			set_screen(cols, rows, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
			repeat (n_items) send_char(random_char());
			drain();
		end

		// let any stray result show up
		repeat (32) @(posedge clk);
		if (mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
